>>> rtl/mlrq_pkg.sv
package mlrq_pkg;

  localparam int MaxThreads = 16;
  localparam int IdxW = $clog2(MaxThreads);
  localparam int CntW = $clog2(MaxThreads + 1);

  localparam logic [7:0] PrioMax = 8'd149;
  localparam logic [7:0] L1Low = 8'd100;
  localparam logic [7:0] L2Low = 8'd50;
  localparam logic [11:0] WaitMax = 12'd4095;

  // request codes
  localparam logic [1:0] ReqEnq = 2'd0;
  localparam logic [1:0] ReqDeq = 2'd1;
  localparam logic [1:0] ReqAge = 2'd2;
  localparam logic [1:0] ReqOther = 2'd3; // no operation

  // status codes
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBadPrio = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  // config register indexes
  localparam logic [1:0] CfgTick = 2'd0;
  localparam logic [1:0] CfgThresh = 2'd1;
  localparam logic [1:0] CfgStep = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_AGE,
    S_PICK,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, clear scan
    logic scan_step; // evaluate entry at scan index
    logic age_step;  // age entry at scan index
    logic commit;    // do enqueue/dequeue write and build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req;
    logic       scan_last;
  } stat_t;

  function automatic logic [1:0] level_of(input logic [7:0] p);
    if (p >= L1Low) return 2'd1;
    if (p >= L2Low) return 2'd2;
    return 2'd3;
  endfunction

endpackage

>>> rtl/mlrq_ctrl.sv
module mlrq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             out_busy,
  input  mlrq_pkg::stat_t  stat,
  output mlrq_pkg::cmd_t   cmd,
  output logic             idle,
  output logic             res_push
);

  mlrq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mlrq_pkg::S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    res_push = 1'b0;
    case (state)
      mlrq_pkg::S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          if (stat.req == mlrq_pkg::ReqAge) state_next = mlrq_pkg::S_AGE;
          else state_next = mlrq_pkg::S_SCAN;
        end
      end
      mlrq_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = mlrq_pkg::S_PICK;
      end
      mlrq_pkg::S_AGE: begin
        cmd.age_step = 1'b1;
        if (stat.scan_last) state_next = mlrq_pkg::S_PICK;
      end
      mlrq_pkg::S_PICK: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_next = mlrq_pkg::S_OUT;
        end
      end
      mlrq_pkg::S_OUT: begin
        res_push = 1'b1;
        state_next = mlrq_pkg::S_IDLE;
      end
      default: state_next = mlrq_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/mlrq_dp.sv
module mlrq_dp (
  input  logic            clk,
  input  logic            rst,
  input  mlrq_pkg::cmd_t  cmd,
  input  logic [47:0]     in_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [11:0]     cfg_data,
  output mlrq_pkg::stat_t stat,
  output logic [47:0]     res_data
);

  localparam int N = mlrq_pkg::MaxThreads;
  localparam int IW = mlrq_pkg::IdxW;

  // config
  logic [9:0]  tick_amount;
  logic [11:0] aging_threshold;
  logic [5:0]  aging_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_amount <= 10'd100;
      aging_threshold <= 12'd1500;
      aging_step <= 6'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        mlrq_pkg::CfgTick: tick_amount <= cfg_data[9:0];
        mlrq_pkg::CfgThresh: aging_threshold <= cfg_data;
        mlrq_pkg::CfgStep: aging_step <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // entry table
  logic [N-1:0] ent_v;
  logic [7:0]   ent_id   [N];
  logic [7:0]   ent_pri  [N];
  logic [15:0]  ent_bur  [N];
  logic [11:0]  ent_wait [N];
  logic [15:0]  ent_arr  [N];
  logic [15:0]  arrival_counter;

  // captured item
  logic [1:0]  req;
  logic [7:0]  q_id, q_pri;
  logic [15:0] q_bur;
  logic [11:0] q_wait;

  // scan state
  logic [IW-1:0] idx;
  logic          have_pick, have_free;
  logic [IW-1:0] pick, free_idx;
  logic [1:0]    pick_lvl;
  logic [15:0]   pick_key;
  logic [7:0]    pick_id;

  // request of the offered item, read by the controller at accept
  assign stat.req = in_data[1:0];
  assign stat.scan_last = (idx == IW'(N - 1));

  // candidate compare for the entry under scan
  logic [1:0]  c_lvl;
  logic [15:0] c_key;
  logic        c_better;
  always_comb begin
    c_lvl = mlrq_pkg::level_of(ent_pri[idx]);
    case (c_lvl)
      2'd1: c_key = ~ent_bur[idx];
      2'd2: c_key = {8'd0, ent_pri[idx]};
      default: c_key = arrival_counter - ent_arr[idx];
    endcase
    if (!have_pick || c_lvl < pick_lvl) c_better = 1'b1;
    else if (c_lvl > pick_lvl) c_better = 1'b0;
    else if (c_key != pick_key) c_better = c_key > pick_key;
    else c_better = ent_id[idx] > pick_id;
  end

  // aging of the entry under scan
  logic [12:0] w_sum, w_sub;
  logic [8:0]  p_sum;
  logic        do_age;
  always_comb begin
    w_sum = {1'b0, ent_wait[idx]} + {3'd0, tick_amount};
    do_age = (w_sum >= {1'b0, aging_threshold}) && (ent_id[idx] != 8'd0);
    w_sub = do_age ? w_sum - {1'b0, aging_threshold} : w_sum;
    p_sum = {1'b0, ent_pri[idx]} + {3'd0, aging_step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_v <= '0;
      arrival_counter <= '0;
    end else begin
      if (cmd.commit) begin
        if (req == mlrq_pkg::ReqEnq && q_pri <= mlrq_pkg::PrioMax && have_free) begin
          ent_v[free_idx] <= 1'b1;
          arrival_counter <= arrival_counter + 16'd1;
        end else if (req == mlrq_pkg::ReqDeq && have_pick) begin
          ent_v[pick] <= 1'b0;
        end
      end
    end
  end

  // payload, scan, entry field and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data[1:0];
      q_id <= in_data[9:2];
      q_pri <= in_data[17:10];
      q_bur <= in_data[33:18];
      q_wait <= in_data[45:34];
      idx <= '0;
      have_pick <= 1'b0;
      have_free <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (!ent_v[idx] && !have_free) begin
        have_free <= 1'b1;
        free_idx <= idx;
      end
      if (ent_v[idx] && c_better) begin
        have_pick <= 1'b1;
        pick <= idx;
        pick_lvl <= c_lvl;
        pick_key <= c_key;
        pick_id <= ent_id[idx];
      end
      idx <= idx + IW'(1);
    end
    if (cmd.age_step) begin
      if (ent_v[idx]) begin
        if (do_age)
          ent_pri[idx] <= (p_sum > {1'b0, mlrq_pkg::PrioMax}) ? mlrq_pkg::PrioMax
                                                             : p_sum[7:0];
        ent_wait[idx] <= (w_sub > {1'b0, mlrq_pkg::WaitMax}) ? mlrq_pkg::WaitMax
                                                             : w_sub[11:0];
      end
      idx <= idx + IW'(1);
    end
    if (cmd.commit) begin
      res_data <= '0;
      case (req)
        mlrq_pkg::ReqEnq: begin
          if (q_pri > mlrq_pkg::PrioMax) res_data[1:0] <= mlrq_pkg::StBadPrio;
          else if (!have_free) res_data[1:0] <= mlrq_pkg::StFull;
          else begin
            ent_id[free_idx] <= q_id;
            ent_pri[free_idx] <= q_pri;
            ent_bur[free_idx] <= q_bur;
            ent_wait[free_idx] <= q_wait;
            ent_arr[free_idx] <= arrival_counter;
          end
        end
        mlrq_pkg::ReqDeq: begin
          if (!have_pick) res_data[1:0] <= mlrq_pkg::StEmpty;
          else begin
            res_data[9:2] <= ent_id[pick];
            res_data[17:10] <= ent_pri[pick];
            res_data[33:18] <= ent_bur[pick];
            res_data[45:34] <= ent_wait[pick];
            res_data[47:46] <= pick_lvl;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/multilevel_ready_queue_aging.sv
// Three-level ready queue with aging over a 16-entry thread table. Every item
// (enqueue, dequeue, aging tick, other) is captured, the table is swept one
// entry per cycle with a single compare/aging unit, the item is committed once
// the output register can take a result, and the result is loaded into it. Input
// is taken only in the idle state; results wait in one output register until taken.
module multilevel_ready_queue_aging (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[1:0], thread_id[9:2], priority_req[17:10], burst_time[33:18],
  // waiting_start[45:34], zero pad
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], thread_id_res[9:2], priority_res[17:10],
  // burst_time_res[33:18], waiting_time[45:34], level[47:46]
  output logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [11:0] cfg_data
);

  mlrq_pkg::cmd_t  cmd;
  mlrq_pkg::stat_t stat;
  logic idle, res_push, in_fire;
  logic [47:0] res_data;

  assign s_tready = idle;
  assign in_fire = s_tvalid && s_tready;

  mlrq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(m_tvalid && !m_tready),
    .stat(stat), .cmd(cmd), .idle(idle), .res_push(res_push)
  );

  mlrq_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_data(s_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .stat(stat), .res_data(res_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (res_push) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_push) m_tdata <= res_data;
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !(m_tvalid && !m_tready)) else $error("result overwrite");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready) else $error("accepted while busy");
  a_push_after: assert property (@(posedge clk) disable iff (rst)
    res_push |=> m_tvalid) else $error("result lost");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

  localparam int Depth = 16;
  localparam int NumRandom = 640;
  localparam longint CycleLimit = 2_000_000;

  // last field in the lowest bits, as on m_tdata
  typedef struct packed {
    logic [1:0]  lvl;
    logic [11:0] wait_t;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [7:0]  tid;
    logic [1:0]  status;
  } sched_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // req_type, thread_id, priority_req, burst_time, waiting_start, zero pad
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // status, thread_id_res, priority_res, burst_time_res, waiting_time, level
  logic [47:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [11:0] cfg_data;

  multilevel_ready_queue_aging dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // shadow copy of the thread table
  logic [9:0]  tick_amt;
  logic [11:0] age_thresh;
  logic [5:0]  age_step;
  logic        tbl_valid [Depth];
  logic [7:0]  tbl_id    [Depth];
  logic [7:0]  tbl_prio  [Depth];
  logic [15:0] tbl_burst [Depth];
  logic [11:0] tbl_wait  [Depth];
  logic [15:0] tbl_arr   [Depth];
  logic [15:0] arr_cnt;

  sched_res_t  expected_q[$];
  int          mismatches;
  int          results_seen;
  int          deq_hits;
  int          age_events;
  longint      cycle_cnt;
  bit          hold_off;
  bit          rx_random;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [1:0] prio_level(logic [7:0] p);
    if (p >= 8'd100) return 2'd1;
    if (p >= 8'd50) return 2'd2;
    return 2'd3;
  endfunction

  // true if table entry a is served before entry b at level lv
  function automatic bit serves_first(int a, int b, logic [1:0] lv);
    logic [15:0] age_a;
    logic [15:0] age_b;
    age_a = arr_cnt - tbl_arr[a];
    age_b = arr_cnt - tbl_arr[b];
    if (lv == 2'd1 && tbl_burst[a] != tbl_burst[b]) return tbl_burst[a] < tbl_burst[b];
    if (lv == 2'd2 && tbl_prio[a] != tbl_prio[b]) return tbl_prio[a] > tbl_prio[b];
    if (lv == 2'd3 && age_a != age_b) return age_a > age_b;
    return tbl_id[a] > tbl_id[b];
  endfunction

  // apply one request to the shadow table, return the expected answer
  function automatic sched_res_t schedule_step(logic [47:0] d);
    sched_res_t r;
    logic [1:0] req;
    int slot;
    int pick;
    int w;
    int p;
    r = '0;
    req = d[1:0];
    if (req == mlrq_pkg::ReqEnq) begin
      if (d[17:10] > mlrq_pkg::PrioMax) begin
        r.status = mlrq_pkg::StBadPrio;
      end else begin
        slot = -1;
        for (int i = Depth - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          r.status = mlrq_pkg::StFull;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_id[slot] = d[9:2];
          tbl_prio[slot] = d[17:10];
          tbl_burst[slot] = d[33:18];
          tbl_wait[slot] = d[45:34];
          tbl_arr[slot] = arr_cnt;
          arr_cnt = arr_cnt + 16'd1;
        end
      end
    end else if (req == mlrq_pkg::ReqDeq) begin
      pick = -1;
      for (int lv = 1; lv <= 3 && pick < 0; lv++) begin
        for (int i = 0; i < Depth; i++) begin
          if (tbl_valid[i] && prio_level(tbl_prio[i]) == lv[1:0])
            if (pick < 0 || serves_first(i, pick, lv[1:0])) pick = i;
        end
        if (pick >= 0) begin
          r.tid = tbl_id[pick];
          r.prio = tbl_prio[pick];
          r.burst = tbl_burst[pick];
          r.wait_t = tbl_wait[pick];
          r.lvl = lv[1:0];
          tbl_valid[pick] = 1'b0;
          deq_hits++;
        end
      end
      if (pick < 0) r.status = mlrq_pkg::StEmpty;
    end else if (req == mlrq_pkg::ReqAge) begin
      for (int i = 0; i < Depth; i++) begin
        if (tbl_valid[i]) begin
          w = tbl_wait[i] + tick_amt;
          if (w >= age_thresh && tbl_id[i] != 8'd0) begin
            p = tbl_prio[i] + age_step;
            tbl_prio[i] = (p > 149) ? 8'd149 : p[7:0];
            w = w - age_thresh;
            age_events++;
          end
          tbl_wait[i] = (w > 4095) ? 12'd4095 : w[11:0];
        end
      end
    end
    return r;
  endfunction

  // receiver: random stalls, long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) m_tready <= 1'b0;
      else if (!rx_random) m_tready <= 1'b1;
      else if ($urandom_range(0, 9) < 7) m_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
        m_tready <= 1'b1;
      end else m_tready <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    sched_res_t got;
    sched_res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", m_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: st %0d/%0d id %0d/%0d pr %0d/%0d",
                      " bu %0d/%0d wt %0d/%0d lv %0d/%0d"},
                     exp_r.status, got.status, exp_r.tid, got.tid, exp_r.prio, got.prio,
                     exp_r.burst, got.burst, exp_r.wait_t, got.wait_t, exp_r.lvl, got.lvl);
        end
      end
    end
  end

  // valid stays high from one item into the next unless a gap is taken
  task automatic send_request(logic [1:0] req, logic [7:0] tid, logic [7:0] prio,
                              logic [15:0] burst, logic [11:0] wstart, bit gaps);
    logic [47:0] d;
    d = {2'b00, wstart, burst, prio, tid, req};
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      if ($urandom_range(0, 15) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(schedule_step(d));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == mlrq_pkg::CfgTick) tick_amt = val[9:0];
    else if (idx == mlrq_pkg::CfgThresh) age_thresh = val;
    else if (idx == mlrq_pkg::CfgStep) age_step = val[5:0];
  endtask

  task automatic enq(logic [7:0] tid, logic [7:0] prio, logic [15:0] b, logic [11:0] w);
    send_request(mlrq_pkg::ReqEnq, tid, prio, b, w, 1'b0);
  endtask

  task automatic deq();
    send_request(mlrq_pkg::ReqDeq, 8'd0, 8'd0, 16'd0, 12'd0, 1'b0);
  endtask

  task automatic tick();
    send_request(mlrq_pkg::ReqAge, 8'd0, 8'd0, 16'd0, 12'd0, 1'b0);
  endtask

  // extremes, bad priority, empty, full table, ties, unknown request, aging
  task automatic test_directed();
    deq();
    enq(8'd255, 8'd255, 16'hFFFF, 12'hFFF);
    enq(8'd5, 8'd150, 16'd1, 12'd1);
    enq(8'd0, 8'd0, 16'd0, 12'd0);
    enq(8'd255, 8'd149, 16'hFFFF, 12'hFFF);
    enq(8'd10, 8'd149, 16'hFFFF, 12'd7);
    enq(8'd20, 8'd99, 16'd3, 12'd4000);
    enq(8'd21, 8'd99, 16'd4, 12'd10);
    enq(8'd1, 8'd49, 16'hAAAA, 12'd1499);
    send_request(mlrq_pkg::ReqOther, 8'hFF, 8'hFF, 16'hFFFF, 12'hFFF, 1'b0);
    tick();
    for (int i = 0; i < 11; i++) enq(8'(i + 30), 8'(i * 13), 16'($urandom), 12'($urandom));
    enq(8'd99, 8'd60, 16'd0, 12'd0);
    for (int i = 0; i < 17; i++) deq();
    wait_drained();
  endtask

  // long output stall while requests keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_request(i[0] ? mlrq_pkg::ReqDeq : mlrq_pkg::ReqEnq, 8'($urandom),
                     8'($urandom_range(0, 149)), 16'($urandom), 12'($urandom), 1'b0);
    join
    wait_drained();
  endtask

  task automatic test_random(int n, logic [9:0] t, logic [11:0] th, logic [5:0] st);
    int k;
    write_reg(mlrq_pkg::CfgTick, {2'b00, t});
    write_reg(mlrq_pkg::CfgThresh, th);
    write_reg(mlrq_pkg::CfgStep, {6'd0, st});
    cfg_we <= 1'b0;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45)
        send_request(mlrq_pkg::ReqEnq, 8'($urandom),
                     (k < 3) ? 8'($urandom) : 8'($urandom_range(0, 149)),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
                     12'($urandom), 1'b1);
      else if (k < 75)
        send_request(mlrq_pkg::ReqDeq, 8'($urandom), 8'($urandom), 16'($urandom),
                     12'($urandom), 1'b1);
      else if (k < 97)
        send_request(mlrq_pkg::ReqAge, 8'($urandom), 8'($urandom), 16'($urandom),
                     12'($urandom), 1'b1);
      else
        send_request(mlrq_pkg::ReqOther, 8'($urandom), 8'($urandom), 16'($urandom),
                     12'($urandom), 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    hold_off = 1'b0;
    rx_random = 1'b0;
    mismatches = 0;
    results_seen = 0;
    deq_hits = 0;
    age_events = 0;
    tick_amt = 10'd100;
    age_thresh = 12'd1500;
    age_step = 6'd10;
    arr_cnt = '0;
    for (int i = 0; i < Depth; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_prio[i] = '0;
      tbl_burst[i] = '0;
      tbl_wait[i] = '0;
      tbl_arr[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    rx_random = 1'b1;
    test_backpressure();
    test_random(NumRandom / 4, 10'd100, 12'd1500, 6'd10);
    test_random(NumRandom / 4, 10'd1000, 12'd1, 6'd50);
    test_random(NumRandom / 4, 10'd1, 12'd4095, 6'd1);
    test_random(NumRandom / 4, 10'd1023, 12'd0, 6'd63);

    $display("Covered %0d results, %0d dequeued threads, %0d aging promotions",
             results_seen, deq_hits, age_events);
    $display("Directed corners, output backpressure and four register settings");
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
